### rtl/aub_pkg.sv
// aub_pkg: widths, register indexes and the pipeline word type shared by
// the alpha unblend front stage, divider cells and top level
// depends on nothing
package aub_pkg;

  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;
  localparam int REM_W  = 2 * PIX_W;
  // one extra quotient bit flags a quotient above the byte range
  localparam int Q_W    = PIX_W + 1;
  localparam int IDX_W  = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    REG_BG_RED   = 2'd0,
    REG_BG_GREEN = 2'd1,
    REG_BG_BLUE  = 2'd2
  } aub_reg_t;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] aub_rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0]             alpha;
    logic [PIX_W-1:0]             den;
    logic [NUM_CH-1:0][REM_W-1:0] rem;
    logic [NUM_CH-1:0][Q_W-1:0]   q;
  } aub_stage_t;

endpackage

### rtl/aub_if.sv
// aub_in_if / aub_out_if: valid-ready pixel channels of the unblend block
// depends on nothing
interface aub_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, alpha, red, green, blue, input ready);
  modport sink   (input valid, alpha, red, green, blue, output ready);
endinterface

interface aub_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, alpha_out, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, alpha_out, red_out, green_out, blue_out, output ready);
endinterface

### rtl/alpha_unblend_from_background.sv
// alpha_unblend_from_background: top level, config registers, front stage,
// row of divider cells and output register
// depends on aub_pkg, aub_if, aub_front, aub_div_cell
//
//   channel   dir  handshake            word
//   in_pix    in   valid/ready          alpha, red, green, blue
//   out_pix   out  valid/ready          alpha_out, red_out, green_out, blue_out
//   cfg_*     in   write enable only    index 0..2, 8-bit background component
//
// one word per cycle sustained unless the receiver stalls; one set-up stage, nine
// divider cells (one quotient bit each, top bit flags saturation), one
// output register. the whole row advances together; when the output word
// is held by out_pix.ready low, every stage holds and in_pix.ready drops.
// synchronous reset clears the valid bits and the background to zero.
module alpha_unblend_from_background
  import aub_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  aub_in_if.sink           in_pix,
  aub_out_if.source        out_pix,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [PIX_W-1:0] cfg_wdata
);

  aub_rgb_t   bg_r;
  aub_rgb_t   color;
  logic       adv;
  logic       out_vld_r;
  logic [PIX_W-1:0] alpha_out_r;
  aub_rgb_t   rgb_out_r;
  aub_rgb_t   rgb_out_nxt;

  aub_stage_t chain [0:Q_W];
  logic       chain_vld [0:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= '0;
    end else if (cfg_we) begin
      case (aub_reg_t'(cfg_idx))
        REG_BG_RED:   bg_r[0] <= cfg_wdata;
        REG_BG_GREEN: bg_r[1] <= cfg_wdata;
        REG_BG_BLUE:  bg_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv          = !out_vld_r || out_pix.ready;
  assign in_pix.ready = adv;
  assign color        = {in_pix.blue, in_pix.green, in_pix.red};

  aub_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_in    (in_pix.valid),
    .alpha     (in_pix.alpha),
    .color     (color),
    .bg        (bg_r),
    .vld_out   (chain_vld[0]),
    .stage_out (chain[0])
  );

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    aub_div_cell #(
      .SHIFT (Q_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .vld_in    (chain_vld[k]),
      .stage_in  (chain[k]),
      .vld_out   (chain_vld[k+1]),
      .stage_out (chain[k+1])
    );
  end

  // top quotient bit set means the quotient left the byte range
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rgb_out_nxt[i] = chain[Q_W].q[i][Q_W-1] ? PIX_MAX : chain[Q_W].q[i][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= chain_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_out_r <= chain[Q_W].alpha;
      rgb_out_r   <= rgb_out_nxt;
    end
  end

  assign out_pix.valid     = out_vld_r;
  assign out_pix.alpha_out = alpha_out_r;
  assign out_pix.red_out   = rgb_out_r[0];
  assign out_pix.green_out = rgb_out_r[1];
  assign out_pix.blue_out  = rgb_out_r[2];

endmodule

### rtl/aub_front.sv
// aub_front: numerator and divisor set-up stage of the unblend pipeline
// depends on aub_pkg
module aub_front
  import aub_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_in,
  input  logic [PIX_W-1:0] alpha,
  input  aub_rgb_t         color,
  input  aub_rgb_t         bg,
  output logic             vld_out,
  output aub_stage_t       stage_out
);

  aub_stage_t stage_nxt, stage_r;
  logic       vld_r;

  always_comb begin
    logic [PIX_W-1:0] inv_a;
    logic [REM_W-1:0] c255;
    logic [REM_W-1:0] prod;
    inv_a = PIX_MAX - alpha;
    stage_nxt = '0;
    stage_nxt.alpha = alpha;
    // zero alpha divides the channel by one, so it passes unchanged
    stage_nxt.den = (alpha == '0) ? PIX_W'(1) : alpha;
    for (int i = 0; i < NUM_CH; i++) begin
      c255 = {color[i], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, color[i]};
      prod = REM_W'(bg[i]) * REM_W'(inv_a);
      if (alpha == '0) begin
        stage_nxt.rem[i] = REM_W'(color[i]);
      end else if (c255 > prod) begin
        stage_nxt.rem[i] = c255 - prod;
      end else begin
        // numerator at or below zero saturates to zero
        stage_nxt.rem[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign stage_out = stage_r;

endmodule

### rtl/aub_div_cell.sv
// aub_div_cell: one restoring-division cell, settles one quotient bit of
// all three channels and hands the word to the next cell
// depends on aub_pkg
module aub_div_cell
  import aub_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       vld_in,
  input  aub_stage_t stage_in,
  output logic       vld_out,
  output aub_stage_t stage_out
);

  aub_stage_t stage_nxt, stage_r;
  logic       vld_r;
  logic [REM_W-1:0] dshift;

  assign dshift = REM_W'(stage_in.den) << SHIFT;

  always_comb begin
    logic take;
    stage_nxt = stage_in;
    for (int i = 0; i < NUM_CH; i++) begin
      take = (stage_in.rem[i] >= dshift);
      if (take) begin
        stage_nxt.rem[i] = stage_in.rem[i] - dshift;
      end
      stage_nxt.q[i] = {stage_in.q[i][Q_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign stage_out = stage_r;

endmodule

### tb/unblend_checker.sv
`timescale 1ns / 1ps
// unblend_checker: watches the pixel channels and config writes of the alpha
// unblend block, predicts each recovered pixel and compares it in order
// depends on aub_pkg and the aub_in_if / aub_out_if interfaces
module unblend_checker
  import aub_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  aub_in_if                in_mon,
  aub_out_if               out_mon,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [PIX_W-1:0] cfg_wdata,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  logic [PIX_W-1:0] bg_red;
  logic [PIX_W-1:0] bg_green;
  logic [PIX_W-1:0] bg_blue;
  pixel_t           expected_pixels[$];

  // exact integer unblend: floor division of a positive numerator, then clamp
  function automatic logic [PIX_W-1:0] recover_channel(input logic [PIX_W-1:0] c,
                                                       input logic [PIX_W-1:0] bg,
                                                       input logic [PIX_W-1:0] a);
    int full;
    int num;
    int quo;
    full = int'(PIX_MAX);
    num  = full * int'(c) - int'(bg) * (full - int'(a));
    if (num <= 0) return '0;
    quo = num / int'(a);
    if (quo > full) return PIX_MAX;
    return quo[PIX_W-1:0];
  endfunction

  function automatic pixel_t unblend_pixel(input pixel_t pix);
    pixel_t res;
    res = pix;
    // zero alpha leaves the color as it came
    if (pix.alpha != '0) begin
      res.red   = recover_channel(pix.red,   bg_red,   pix.alpha);
      res.green = recover_channel(pix.green, bg_green, pix.alpha);
      res.blue  = recover_channel(pix.blue,  bg_blue,  pix.alpha);
    end
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [PIX_W-1:0] exp_v,
                                      input logic [PIX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pixel_t pix;
    pixel_t want;
    if (!rst_n) begin
      bg_red   = '0;
      bg_green = '0;
      bg_blue  = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_BG_RED:   bg_red   = cfg_wdata;
          REG_BG_GREEN: bg_green = cfg_wdata;
          REG_BG_BLUE:  bg_blue  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pix = '{in_mon.alpha, in_mon.red, in_mon.green, in_mon.blue};
        expected_pixels.push_back(unblend_pixel(pix));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected word: alpha_out %0d red_out %0d green_out %0d blue_out %0d",
                 out_mon.alpha_out, out_mon.red_out, out_mon.green_out, out_mon.blue_out);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("alpha_out", want.alpha, out_mon.alpha_out);
          check_field("red_out",   want.red,   out_mon.red_out);
          check_field("green_out", want.green, out_mon.green_out);
          check_field("blue_out",  want.blue,  out_mon.blue_out);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

### tb/alpha_unblend_from_background_tb.sv
`timescale 1ns / 1ps
// alpha_unblend_from_background_tb: drives pixels and background settings
// into the unblend block with bursty input and a stalling receiver
// depends on aub_pkg, the aub interfaces, the block and unblend_checker
module alpha_unblend_from_background_tb;
  import aub_pkg::*;

  localparam int                LATENCY          = 11;
  localparam int                HOLD_OFF_CYCLES  = 300;
  localparam int                WATCHDOG_LIMIT   = 3000;
  localparam int                RANDOM_PHASES    = 6;
  localparam int                WORDS_PER_PHASE  = 225;
  localparam logic [IDX_W-1:0]  REG_UNUSED       = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [PIX_W-1:0] cfg_wdata;
  int               mismatches;
  int               words_in_flight;
  int               idle_cycles;
  int               burst_left;
  bit               hold_off_req;

  aub_in_if  in_pix();
  aub_out_if out_pix();

  alpha_unblend_from_background DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  unblend_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_pix),
    .out_mon   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .errors    (mismatches),
    .pending   (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one word and hold it until taken; bursts end in a random gap
  task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] r,
                            input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    bit taken;
    int gap;
    in_pix.valid <= 1'b1;
    in_pix.alpha <= a;
    in_pix.red   <= r;
    in_pix.green <= g;
    in_pix.blue  <= b;
    do begin
      @(negedge clk);
      taken = in_pix.ready;
      @(posedge clk);
    end while (!taken);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_pixel();
    logic [PIX_W-1:0] a;
    case ($urandom_range(0, 9))
      0:       a = '0;
      1:       a = PIX_MAX;
      2:       a = PIX_W'($urandom_range(1, 4));
      default: a = PIX_W'($urandom_range(0, 255));
    endcase
    send_pixel(a, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
               PIX_W'($urandom_range(0, 255)));
  endtask

  // stop offering and let every word in flight come out
  task automatic drain_pipeline();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_background(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                input logic [PIX_W-1:0] b, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BG_RED;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_idx   <= REG_BG_GREEN;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_idx   <= REG_BG_BLUE;
    cfg_wdata <= b;
    @(posedge clk);
    // index past the register list must change nothing
    if (poke_unused) begin
      cfg_idx   <= REG_UNUSED;
      cfg_wdata <= PIX_W'($urandom_range(0, 255));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: stretches of free flow, random and heavy stalls, one long hold-off
  initial begin
    int mode;
    int len;
    out_pix.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_pix.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        case (mode)
          0:       out_pix.ready <= 1'b1;
          1:       out_pix.ready <= 1'($urandom_range(0, 1));
          2:       out_pix.ready <= ($urandom_range(0, 3) == 0);
          default: out_pix.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [PIX_W-1:0] bg_r;
    logic [PIX_W-1:0] bg_g;
    logic [PIX_W-1:0] bg_b;
    hold_off_req  = 1'b0;
    burst_left    = 1;
    idle_cycles   = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_BG_RED;
    cfg_wdata    <= '0;
    in_pix.valid <= 1'b0;
    in_pix.alpha <= '0;
    in_pix.red   <= '0;
    in_pix.green <= '0;
    in_pix.blue  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // background still at its reset value of black
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd128);
    send_pixel(8'd1,   8'd1,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd2,   8'd1,   8'd3);
    send_pixel(8'd128, 8'd64,  8'd127, 8'd128);
    drain_pipeline();

    // mixed background: negative and saturating numerators
    set_background(8'd200, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd1,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd17,  8'd34,  8'd51);
    send_pixel(8'd255, 8'd0,   8'd255, 8'd77);
    send_pixel(8'd254, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd100, 8'd100, 8'd100, 8'd100);
    send_pixel(8'd2,   8'd200, 8'd255, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd255, 8'd0);
    send_pixel(8'd200, 8'd180, 8'd250, 8'd10);
    send_pixel(8'd1,   8'd255, 8'd255, 8'd255);
    send_pixel(8'd64,  8'd57,  8'd250, 8'd1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd85,  8'd170, 8'd85);
    drain_pipeline();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin bg_r = PIX_MAX; bg_g = PIX_MAX; bg_b = PIX_MAX; end
        1: begin bg_r = '0;      bg_g = '0;      bg_b = '0;      end
        default: begin
          bg_r = PIX_W'($urandom_range(0, 255));
          bg_g = PIX_W'($urandom_range(0, 255));
          bg_b = PIX_W'($urandom_range(0, 255));
        end
      endcase
      set_background(bg_r, bg_g, bg_b, 1'($urandom_range(0, 1)));
      // fill the block while the receiver holds off
      if (phase == 2) hold_off_req = 1'b1;
      repeat (WORDS_PER_PHASE) send_random_pixel();
      drain_pipeline();
    end

    if (mismatches == 0 && words_in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/aub_pkg.sv
rtl/aub_if.sv
rtl/aub_front.sv
rtl/aub_div_cell.sv
rtl/alpha_unblend_from_background.sv
tb/unblend_checker.sv
tb/alpha_unblend_from_background_tb.sv
